/* rtl/tag_presence_toggle_table_macros.svh */
// ----------------------------------------------------------------------------
// Tag presence toggle table assertion macros
// Concurrent assertion helpers that disappear when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TAG_PRESENCE_TOGGLE_TABLE_MACROS_SVH
`define TAG_PRESENCE_TOGGLE_TABLE_MACROS_SVH

`ifndef SYNTH
`define TPT_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("tpt assertion failed");
`define TPT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("tpt assertion failed");
`else
`define TPT_ASSERT_SAME(label, clk, rst, a, b)
`define TPT_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

/* rtl/tpt_pkg.sv */
// ----------------------------------------------------------------------------
// Tag presence toggle table package
// Result codes, fixed field widths and the result word type.
// ----------------------------------------------------------------------------
package tpt_pkg;

   localparam int BYTE_W     = 8;
   localparam int ACT_W      = 2;
   localparam int SLOT_OUT_W = 3;
   localparam int FREE_OUT_W = 4;

   localparam logic [ACT_W-1:0] ACT_REMOVED = 2'd0;
   localparam logic [ACT_W-1:0] ACT_STORED  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FULL    = 2'd2;

   typedef struct packed {
      logic                  strobe;
      logic [ACT_W-1:0]      action;
      logic [SLOT_OUT_W-1:0] slot;
      logic [FREE_OUT_W-1:0] free_slots;
   } rsp_type;

endpackage

/* rtl/tag_presence_toggle_table.sv */
// ----------------------------------------------------------------------------
// Tag presence toggle table
// Toggles tags in and out of a small slot table, one result per tag.
// ----------------------------------------------------------------------------
// A byte word on req_tag_byte is taken at a rising edge with start high and
// busy low. Every TAG_LEN bytes form one tag, which goes into a two-entry
// queue. The scanner reads the slot memory one slot at a time: a tag
// that is present frees its slot, an absent one fills the lowest empty
// slot, and with no empty slot the table reports full.
// Each tag gives one result word on rsp_action, rsp_slot and rsp_free_slots,
// marked by rsp_strobe for exactly one cycle. The receiver cannot stall.
// Each slot is read in ST_READ and compared in ST_CMP. A match ends the
// walk with its result; otherwise every slot is walked and ST_ALLOC then
// stores the tag or reports full. The scanner works on one tag at a time.
// busy is high while the queue holds two tags.
// Reset empties the queue and all slots, sets the free count to SLOTS and
// restarts byte assembly at the first byte of a tag.
// ----------------------------------------------------------------------------
`include "tag_presence_toggle_table_macros.svh"

module tag_presence_toggle_table
   import tpt_pkg::*;
#(
   parameter int SLOTS   = 8,
   parameter int TAG_LEN = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [BYTE_W-1:0]     req_tag_byte,
   output logic                  rsp_strobe,
   output logic [ACT_W-1:0]      rsp_action,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [FREE_OUT_W-1:0] rsp_free_slots
);

   logic                      byte_accept;
   logic                      push;
   logic [TAG_LEN*BYTE_W-1:0] push_tag;
   logic                      pop;
   logic                      q_full;
   logic                      q_empty;
   logic [TAG_LEN*BYTE_W-1:0] head_tag;
   rsp_type                   rsp;
   logic                      rsp_full;

   assign busy        = q_full;
   assign byte_accept = start && !busy;

   tpt_front #(
      .TAG_LEN (TAG_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .tag_byte    (req_tag_byte),
      .push        (push),
      .push_tag    (push_tag)
   );

   tpt_fifo #(
      .TAG_LEN (TAG_LEN)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tag (push_tag),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_tag (head_tag)
   );

   tpt_back #(
      .SLOTS   (SLOTS),
      .TAG_LEN (TAG_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tag_ready (!q_empty),
      .head_tag  (head_tag),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_strobe     = rsp.strobe;
   assign rsp_action     = rsp.action;
   assign rsp_slot       = rsp.slot;
   assign rsp_free_slots = rsp.free_slots;

   assign rsp_full = rsp_strobe && (rsp_action == ACT_FULL);

   // A result always costs a fresh read and compare, so strobes never abut.
   `TPT_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe)
   `TPT_ASSERT_SAME(a_full_slot_zero, clock, reset, rsp_full, rsp_slot == '0)
   // A result word only appears after a tag was taken out of the queue.
   `TPT_ASSERT_NEXT(a_result_needs_pop, clock, reset, !pop, !rsp_strobe)

endmodule

/* rtl/tpt_front.sv */
// ----------------------------------------------------------------------------
// Tag assembler
// Collects tag bytes and hands each completed tag to the queue.
// ----------------------------------------------------------------------------
module tpt_front
   import tpt_pkg::*;
#(
   parameter int TAG_LEN = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_accept,
   input  logic [BYTE_W-1:0]         tag_byte,
   output logic                      push,
   output logic [TAG_LEN*BYTE_W-1:0] push_tag
);

   localparam int POS_W = (TAG_LEN > 1) ? $clog2(TAG_LEN) : 1;

   logic [BYTE_W-1:0] asm_ff [TAG_LEN];
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic              last_byte;

   assign last_byte = (pos_ff == POS_W'(TAG_LEN - 1));
   assign push      = byte_accept && last_byte;

   always_comb begin
      pos_in = pos_ff;
      if (byte_accept) begin
         pos_in = last_byte ? '0 : pos_ff + POS_W'(1);
      end
   end

   // The final byte goes straight into the word pushed to the queue.
   always_comb begin
      for (int i = 0; i < TAG_LEN; i++) begin
         push_tag[i*BYTE_W +: BYTE_W] = (i == TAG_LEN - 1) ? tag_byte : asm_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_accept) begin
         asm_ff[pos_ff] <= tag_byte;
      end
   end

endmodule

/* rtl/tpt_fifo.sv */
// ----------------------------------------------------------------------------
// Tag queue
// Two-entry queue of completed tags between the assembler and the scanner.
// ----------------------------------------------------------------------------
module tpt_fifo
   import tpt_pkg::*;
#(
   parameter int TAG_LEN = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [TAG_LEN*BYTE_W-1:0] push_tag,
   input  logic                      pop,
   output logic                      full,
   output logic                      empty,
   output logic [TAG_LEN*BYTE_W-1:0] head_tag
);

   logic [TAG_LEN*BYTE_W-1:0] entry_ff [2];
   logic                      wr_ptr_ff;
   logic                      wr_ptr_in;
   logic                      rd_ptr_ff;
   logic                      rd_ptr_in;
   logic [1:0]                count_ff;
   logic [1:0]                count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_tag = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_tag;
      end
   end

endmodule

/* rtl/tpt_back.sv */
// ----------------------------------------------------------------------------
// Slot scanner
// Walks the slot table one slot at a time, frees a matching slot, else fills or reports full.
// ----------------------------------------------------------------------------
module tpt_back
   import tpt_pkg::*;
#(
   parameter int SLOTS   = 8,
   parameter int TAG_LEN = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tag_ready,
   input  logic [TAG_LEN*BYTE_W-1:0] head_tag,
   output logic                      pop,
   output rsp_type                   rsp
);

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_W = $clog2(SLOTS + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;
   localparam logic [1:0] ST_ALLOC = 2'd3;

   logic [TAG_LEN*BYTE_W-1:0] mem_ff [SLOTS];
   logic [TAG_LEN*BYTE_W-1:0] rd_data_ff;

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   logic [SLOT_W-1:0]     idx_ff;
   logic [SLOT_W-1:0]     idx_in;
   logic                  found_ff;
   logic                  found_in;
   logic [SLOT_W-1:0]     free_idx_ff;
   logic [SLOT_W-1:0]     free_idx_in;
   logic [SLOTS-1:0]      valid_ff;
   logic [SLOTS-1:0]      valid_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic                  mem_we;

   logic                  rsp_strobe_ff;
   logic                  rsp_strobe_in;
   logic [ACT_W-1:0]      rsp_action_ff;
   logic [ACT_W-1:0]      rsp_action_in;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [SLOT_W-1:0]     rsp_slot_in;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic                  hit;

   assign hit = valid_ff[idx_ff] && (rd_data_ff == head_tag);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      pop           = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_action_in = ACT_FULL;
      rsp_slot_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (tag_ready) begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (hit) begin
               valid_in[idx_ff] = 1'b0;
               if (count_ff < COUNT_W'(SLOTS)) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               rsp_strobe_in = 1'b1;
               rsp_action_in = ACT_REMOVED;
               rsp_slot_in   = idx_ff;
               pop           = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               // Remember the lowest empty slot seen during the walk.
               if (!valid_ff[idx_ff] && !found_ff) begin
                  found_in    = 1'b1;
                  free_idx_in = idx_ff;
               end
               if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                  state_in = ST_ALLOC;
               end else begin
                  idx_in   = idx_ff + SLOT_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_ALLOC: begin
            rsp_strobe_in = 1'b1;
            pop           = 1'b1;
            state_in      = ST_IDLE;
            if (found_ff) begin
               mem_we                = 1'b1;
               valid_in[free_idx_ff] = 1'b1;
               if (count_ff > '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
               rsp_action_in = ACT_STORED;
               rsp_slot_in   = free_idx_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         free_idx_ff   <= '0;
         valid_ff      <= '0;
         count_ff      <= COUNT_W'(SLOTS);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         found_ff      <= found_in;
         free_idx_ff   <= free_idx_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_action_ff <= rsp_action_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= count_in;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[idx_ff];
      if (mem_we) begin
         mem_ff[free_idx_ff] <= head_tag;
      end
   end

   assign rsp.strobe     = rsp_strobe_ff;
   assign rsp.action     = rsp_action_ff;
   assign rsp.slot       = SLOT_OUT_W'(rsp_slot_ff);
   assign rsp.free_slots = FREE_OUT_W'(rsp_count_ff);

endmodule

/* sim/tag_presence_toggle_table_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tag presence toggle table testbench
// Feeds tag bytes with random gaps, predicts the remove, store and full
// decisions per completed tag and checks every result word in order.
// ----------------------------------------------------------------------------
module tag_presence_toggle_table_test;
   import tpt_pkg::*;

   localparam int SLOTS      = 8;
   localparam int TAG_LEN    = 14;
   localparam int TAG_W      = TAG_LEN * BYTE_W;
   localparam int POOL_N     = 11;
   localparam int BYTE_GOAL  = 1900;
   localparam int DRAIN      = 4 * SLOTS + 8;
   localparam int CYCLE_CAP  = 100000;

   typedef struct {
      logic [BYTE_W-1:0] data;
      bit                hold;
      bit                calm;
   } tag_word_type;

   typedef struct {
      logic [ACT_W-1:0]      action;
      logic [SLOT_OUT_W-1:0] slot;
      logic [FREE_OUT_W-1:0] free_slots;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [BYTE_W-1:0]     req_tag_byte = '0;
   logic                  rsp_strobe;
   logic [ACT_W-1:0]      rsp_action;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic [FREE_OUT_W-1:0] rsp_free_slots;

   tag_word_type send_queue[$];
   outcome_type  pending_outcomes[$];
   bit           word_taken = 1'b0;
   int unsigned  fault_count = 0;
   int unsigned  cycle_count = 0;

   // Predicted block state.
   logic [TAG_W-1:0] building_tag;
   int               build_pos = 0;
   logic [TAG_W-1:0] stored_tags [SLOTS];
   logic [SLOTS-1:0] occupied = '0;
   int               free_left = SLOTS;

   logic [TAG_W-1:0] tag_pool [POOL_N];

   tag_presence_toggle_table #(
      .SLOTS   (SLOTS),
      .TAG_LEN (TAG_LEN)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_tag_byte   (req_tag_byte),
      .rsp_strobe     (rsp_strobe),
      .rsp_action     (rsp_action),
      .rsp_slot       (rsp_slot),
      .rsp_free_slots (rsp_free_slots)
   );

   always #10 clock = ~clock;

   // Adds one byte to the tag under assembly; a completed tag toggles its
   // presence in the table and yields one expected result word.
   task automatic track_tag_byte(input logic [BYTE_W-1:0] b);
      outcome_type o;
      int          hit;
      int          vacant;
      hit = -1;
      vacant = -1;
      building_tag[build_pos*BYTE_W +: BYTE_W] = b;
      build_pos++;
      if (build_pos == TAG_LEN) begin
         build_pos = 0;
         // Scan downward so that the lowest matching and lowest empty slot win.
         for (int s = SLOTS - 1; s >= 0; s--) begin
            if (occupied[s] && stored_tags[s] == building_tag) hit = s;
            if (!occupied[s]) vacant = s;
         end
         if (hit >= 0) begin
            occupied[hit] = 1'b0;
            if (free_left < SLOTS) free_left++;
            o.action = ACT_REMOVED;
            o.slot = SLOT_OUT_W'(hit);
         end else if (vacant >= 0) begin
            stored_tags[vacant] = building_tag;
            occupied[vacant] = 1'b1;
            if (free_left > 0) free_left--;
            o.action = ACT_STORED;
            o.slot = SLOT_OUT_W'(vacant);
         end else begin
            o.action = ACT_FULL;
            o.slot = '0;
         end
         o.free_slots = FREE_OUT_W'(free_left);
         pending_outcomes.push_back(o);
      end
   endtask

   task automatic queue_tag(input logic [TAG_W-1:0] tag, input bit hold, input bit calm);
      tag_word_type w;
      for (int i = 0; i < TAG_LEN; i++) begin
         w.data = tag[i*BYTE_W +: BYTE_W];
         w.hold = hold && (i == 0);
         w.calm = calm;
         send_queue.push_back(w);
      end
   endtask

   // Acceptance of bytes and checking of result words.
   always @(posedge clock) begin : monitor
      outcome_type head;
      if (!reset) begin
         if (start && !busy) begin
            track_tag_byte(req_tag_byte);
            word_taken = 1'b1;
         end
         if (rsp_strobe) begin
            if (pending_outcomes.size() == 0) begin
               $error("result word with no expectation: action %0d slot %0d free_slots %0d",
                      rsp_action, rsp_slot, rsp_free_slots);
               fault_count++;
            end else begin
               head = pending_outcomes.pop_front();
               if (rsp_action !== head.action) begin
                  $error("action expected %0d actual %0d", head.action, rsp_action);
                  fault_count++;
               end
               if (rsp_slot !== head.slot) begin
                  $error("slot expected %0d actual %0d", head.slot, rsp_slot);
                  fault_count++;
               end
               if (rsp_free_slots !== head.free_slots) begin
                  $error("free_slots expected %0d actual %0d",
                         head.free_slots, rsp_free_slots);
                  fault_count++;
               end
            end
         end
      end
   end

   // Presents one byte word at a time and holds it until it is taken.
   always @(negedge clock) begin : driver
      logic next_start;
      bit   idle;
      bit   waiting;
      next_start = start;
      if (!reset) begin
         if (word_taken) begin
            word_taken = 1'b0;
            next_start = 1'b0;
         end
         if (!next_start && send_queue.size() > 0) begin
            idle = !send_queue[0].calm && ($urandom_range(99) < 11);
            waiting = send_queue[0].hold && (pending_outcomes.size() != 0);
            if (!idle && !waiting) begin
               req_tag_byte <= send_queue[0].data;
               void'(send_queue.pop_front());
               next_start = 1'b1;
            end
         end
      end
      start <= next_start;
   end

   initial begin
      while (cycle_count < CYCLE_CAP) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [TAG_W-1:0] tag;
      int               tag_index;
      int unsigned      pick;
      int unsigned      bytes_queued;

      for (int p = 0; p < POOL_N; p++) begin
         for (int i = 0; i < TAG_LEN; i++) begin
            tag_pool[p][i*BYTE_W +: BYTE_W] = BYTE_W'($urandom);
         end
      end

      // A blank tag is a real key: store it, add an all-ones tag, remove it.
      queue_tag('0, 1'b0, 1'b0);
      queue_tag('1, 1'b0, 1'b0);
      queue_tag('0, 1'b0, 1'b0);
      // Walk the table into the full state with random keys.
      for (int p = 0; p < 10; p++) queue_tag(tag_pool[p], 1'b0, 1'b0);

      bytes_queued = 13 * TAG_LEN;
      tag_index = 0;
      while (bytes_queued < BYTE_GOAL) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            // A near miss of a pool key differs in a single bit; it is sent twice, so
            // it goes in and comes straight back out unless the table is full.
            tag = tag_pool[$urandom_range(POOL_N - 1)];
            tag[$urandom_range(TAG_W - 1)] ^= 1'b1;
            queue_tag(tag, tag_index == 30, tag_index >= 50 && tag_index < 80);
            queue_tag(tag, 1'b0, tag_index >= 50 && tag_index < 80);
            bytes_queued += 2 * TAG_LEN;
         end else begin
            queue_tag(tag_pool[$urandom_range(POOL_N - 1)],
                      tag_index == 30 || tag_index == 100,
                      tag_index >= 50 && tag_index < 80);
            bytes_queued += TAG_LEN;
         end
         tag_index++;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (send_queue.size() != 0 || start) @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
